// ----- sv/fof_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the first-occurrence filter.
// Depends on nothing; used by fof_match and first_occurrence_filter.

package fof_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int VALUE_W     = 32;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

// ----- sv/fof_match.sv -----
`timescale 1ns / 1ps
// Shared comparator of the first-occurrence filter: exact or magnitude match.
// Depends on fof_pkg for the value width.

module fof_match (
	input  logic [fof_pkg::VALUE_W-1:0] stored,
	input  logic [fof_pkg::VALUE_W-1:0] probe,
	input  logic                        by_magnitude,
	output logic                        hit
);

	logic [fof_pkg::VALUE_W-1:0] stored_mag;
	logic [fof_pkg::VALUE_W-1:0] probe_mag;

	// The magnitude is an unsigned number, so the most negative value maps to itself.
	assign stored_mag = stored[fof_pkg::VALUE_W-1] ? (~stored + 1'b1) : stored;
	assign probe_mag  = probe[fof_pkg::VALUE_W-1] ? (~probe + 1'b1) : probe;

	assign hit = by_magnitude ? (stored_mag == probe_mag) : (stored == probe);

endmodule

// ----- sv/first_occurrence_filter.sv -----
`timescale 1ns / 1ps
// After start is accepted, the sequencer steps through ST_SCAN and ST_DONE, and the result
// strobe rises from the register set in ST_DONE; busy stays high until ST_DONE is left.
// A new item is accepted only in ST_IDLE, after the last one is done; one shared
// comparator walks the seen table, one registered read per cycle, and stops at the first hit.
// Reset clears the entry count, the mode register and the sequencer; the table is not cleared.
// The result strobe lasts one cycle and the receiver cannot stall it.

module first_occurrence_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic                               cfg_data,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [fof_pkg::VALUE_W-1:0] value,
	input  logic                               end_of_list,
	output logic                               result_valid,
	output logic signed [fof_pkg::VALUE_W-1:0] value_out,
	output logic                               keep,
	output logic                               overflow,
	output logic                               last_out
);

	fof_pkg::state_t             state_q;
	logic                        mode_q;
	logic [fof_pkg::CNT_W-1:0]   count_q;
	logic [fof_pkg::CNT_W-1:0]   idx_q;
	logic [fof_pkg::VALUE_W-1:0] value_q;
	logic                        last_q;
	logic                        hit_q;
	logic                        pend_s1;
	logic [fof_pkg::VALUE_W-1:0] rd_data_s1;
	logic                        valid_q;
	logic [fof_pkg::VALUE_W-1:0] vout_q;
	logic                        keep_q;
	logic                        ovf_q;
	logic                        lout_q;

	logic [fof_pkg::VALUE_W-1:0] mem [fof_pkg::TABLE_DEPTH];

	logic accept;
	logic issue;
	logic cmp_hit;
	logic match;
	logic scan_end;
	logic room;

	assign accept   = start && (state_q == fof_pkg::ST_IDLE);
	assign issue    = (state_q == fof_pkg::ST_SCAN) && (idx_q < count_q);
	assign match    = pend_s1 && cmp_hit;
	assign scan_end = match || !issue;
	assign room     = count_q < fof_pkg::CNT_W'(fof_pkg::TABLE_DEPTH);

	fof_match u_match (
		.stored       (rd_data_s1),
		.probe        (value_q),
		.by_magnitude (mode_q),
		.hit          (cmp_hit)
	);

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[idx_q[fof_pkg::ADDR_W-1:0]];
		end
		if ((state_q == fof_pkg::ST_DONE) && !hit_q && room) begin
			mem[count_q[fof_pkg::ADDR_W-1:0]] <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
			last_q  <= end_of_list;
		end
		if (state_q == fof_pkg::ST_DONE) begin
			vout_q <= value_q;
			keep_q <= !hit_q;
			ovf_q  <= !hit_q && !room;
			lout_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fof_pkg::ST_IDLE;
			mode_q  <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			pend_s1 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			if (cfg_write) begin
				mode_q <= cfg_data;
			end
			unique case (state_q)
				fof_pkg::ST_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						hit_q   <= 1'b0;
						pend_s1 <= 1'b0;
						state_q <= fof_pkg::ST_SCAN;
					end
				end
				fof_pkg::ST_SCAN: begin
					pend_s1 <= issue && !match;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_end) begin
						hit_q   <= match;
						pend_s1 <= 1'b0;
						state_q <= fof_pkg::ST_DONE;
					end
				end
				fof_pkg::ST_DONE: begin
					valid_q <= 1'b1;
					if (last_q) begin
						count_q <= '0;
					end else if (!hit_q && room) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= fof_pkg::ST_IDLE;
				end
				default: begin
					state_q <= fof_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != fof_pkg::ST_IDLE);
	assign result_valid = valid_q;
	assign value_out    = vout_q;
	assign keep         = keep_q;
	assign overflow     = ovf_q;
	assign last_out     = lout_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fof_pkg::CNT_W'(fof_pkg::TABLE_DEPTH))
		else $error("Seen count exceeds the table depth.");

	a_strobe_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(state_q == fof_pkg::ST_DONE))
		else $error("Result transfer without a finished scan.");

	a_overflow_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && ovf_q |-> keep_q && ($past(count_q) == fof_pkg::CNT_W'(fof_pkg::TABLE_DEPTH)))
		else $error("Overflow reported without a full table.");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !valid_q)
		else $error("Accepted transfer did not start a scan.");
`endif

endmodule
